FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define BRPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define BRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/brpc_pkg.sv
// ----------------------------------------------------------------------------
// Binary RPC body parser package
// Widths, phase codes, byte classes, status codes and shared types.
// ----------------------------------------------------------------------------
package brpc_pkg;

    localparam int DATA_W   = 8;
    localparam int ID_W     = 64;
    localparam int LEN_W    = 32;
    localparam int CNT_W    = 3;
    localparam int PHASE_W  = 4;
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 80;

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_VER    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_MLEN   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_METHOD = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PLEN   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_PARAMS = 4'd4;
    localparam logic [PHASE_W-1:0] PH_QID    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_SID    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_HASRES = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RLEN   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RES    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_HASERR = 4'd10;
    localparam logic [PHASE_W-1:0] PH_ELEN   = 4'd11;
    localparam logic [PHASE_W-1:0] PH_ERR    = 4'd12;
    localparam logic [PHASE_W-1:0] PH_DONE   = 4'd13;
    localparam logic [PHASE_W-1:0] PH_FAIL   = 4'd14;

    // Byte classes
    localparam logic [CLASS_W-1:0] CLS_FRAME   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_METHOD  = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_PARAMS  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_RESULT  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_ERROR   = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_IGNORED = 3'd5;

    // Completion status
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd2;

    // Layout select
    localparam logic KIND_REQUEST  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam logic [DATA_W-1:0] VERSION_ONE = 8'd1;

    // Value of the byte counter on the final byte of each multi-byte field
    localparam logic [CNT_W-1:0] CNT_LAST_LEN16 = 3'd1;
    localparam logic [CNT_W-1:0] CNT_LAST_LEN32 = 3'd3;
    localparam logic [CNT_W-1:0] CNT_LAST_ID    = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [CLASS_W-1:0]  byte_class;
        logic [DATA_W-1:0]   payload_byte;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     body_id;
        logic                has_result_flag;
        logic                has_error_flag;
    } t_result;

endpackage

FILE: design/brpc_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one body byte per transfer and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module brpc_in_reg
    import brpc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_item  i_item,
    input  logic   i_adv,
    output logic   o_valid,
    output t_item  o_item
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_adv;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load the byte on a transfer
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/brpc_core.sv
// ----------------------------------------------------------------------------
// Parse core
// Phase tracking, length and id assembly, byte classification and status.
// ----------------------------------------------------------------------------
module brpc_core
    import brpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_item              i_item,
    input  logic               i_message_kind,
    output t_result            o_result,
    output logic [PHASE_W-1:0] o_phase
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic [ID_W-1:0]    r_id,    n_id;
    logic               r_fail,  n_fail;
    logic [1:0]         r_flags, n_flags;

    logic [LEN_W-1:0]   shifted_len;
    logic [LEN_W-1:0]   dec_len;
    logic [ID_W-1:0]    shifted_id;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CLASS_W-1:0] cls;
    logic [STATUS_W-1:0] status;

    assign shifted_len = {r_len[LEN_W-DATA_W-1:0], i_item.data};
    assign shifted_id  = {r_id[ID_W-DATA_W-1:0], i_item.data};
    assign dec_len     = (r_len != '0) ? (r_len - 32'd1) : '0;
    assign cnt_inc     = r_cnt + 3'd1;

    // Advance the parse by one byte
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_id    = r_id;
        n_fail  = r_fail;
        n_flags = r_flags;
        cls     = CLS_FRAME;
        case (r_phase)
            PH_VER: begin
                n_cnt = '0;
                n_len = '0;
                n_id  = '0;
                if (i_item.data != VERSION_ONE) begin
                    n_fail  = 1'b1;
                    n_phase = PH_FAIL;
                end else if (i_message_kind == KIND_RESPONSE) begin
                    n_phase = PH_SID;
                end else begin
                    n_phase = PH_MLEN;
                end
            end
            PH_MLEN: begin
                n_len = shifted_len;
                if (r_cnt == CNT_LAST_LEN16) begin
                    n_cnt   = '0;
                    n_phase = (shifted_len != '0) ? PH_METHOD : PH_PLEN;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_METHOD: begin
                cls   = CLS_METHOD;
                n_len = dec_len;
                if (dec_len == '0) begin
                    n_phase = PH_PLEN;
                end
            end
            PH_PLEN: begin
                n_len = shifted_len;
                if (r_cnt == CNT_LAST_LEN32) begin
                    n_cnt   = '0;
                    n_phase = (shifted_len != '0) ? PH_PARAMS : PH_QID;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_PARAMS: begin
                cls   = CLS_PARAMS;
                n_len = dec_len;
                if (dec_len == '0) begin
                    n_phase = PH_QID;
                end
            end
            PH_QID, PH_SID: begin
                n_id = shifted_id;
                if (r_cnt == CNT_LAST_ID) begin
                    n_cnt   = '0;
                    n_phase = (r_phase == PH_QID) ? PH_DONE : PH_HASRES;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_HASRES: begin
                n_len = '0;
                n_cnt = '0;
                if (i_item.data != '0) begin
                    n_flags[0] = 1'b1;
                    n_phase    = PH_RLEN;
                end else begin
                    n_phase = PH_HASERR;
                end
            end
            PH_RLEN: begin
                n_len = shifted_len;
                if (r_cnt == CNT_LAST_LEN32) begin
                    n_cnt   = '0;
                    n_phase = (shifted_len != '0) ? PH_RES : PH_HASERR;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_RES: begin
                cls   = CLS_RESULT;
                n_len = dec_len;
                if (dec_len == '0) begin
                    n_phase = PH_HASERR;
                end
            end
            PH_HASERR: begin
                n_len = '0;
                n_cnt = '0;
                if (i_item.data != '0) begin
                    n_flags[1] = 1'b1;
                    n_phase    = PH_ELEN;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_ELEN: begin
                n_len = shifted_len;
                if (r_cnt == CNT_LAST_LEN32) begin
                    n_cnt   = '0;
                    n_phase = (shifted_len != '0) ? PH_ERR : PH_DONE;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            PH_ERR: begin
                cls   = CLS_ERROR;
                n_len = dec_len;
                if (dec_len == '0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                // Finished, failed or unused phase: drop the byte
                cls = CLS_IGNORED;
            end
        endcase

        // Final status from the state after this byte
        if (n_fail) begin
            status = ST_BAD_VER;
        end else if (n_phase == PH_DONE) begin
            status = ST_OK;
        end else begin
            status = ST_TRUNC;
        end

        // Build the result; status fields only on the last byte
        o_result.byte_class      = cls;
        o_result.payload_byte    = i_item.data;
        o_result.done_res        = i_item.last;
        o_result.status          = i_item.last ? status : ST_OK;
        o_result.body_id         = (i_item.last && status == ST_OK) ? n_id : '0;
        o_result.has_result_flag = i_item.last & n_flags[0];
        o_result.has_error_flag  = i_item.last & n_flags[1];

        // Return to the start of a body after the last byte
        if (i_item.last) begin
            n_phase = PH_VER;
            n_cnt   = '0;
            n_len   = '0;
            n_id    = '0;
            n_fail  = 1'b0;
            n_flags = '0;
        end
    end

    // Commit the parse state when a byte moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VER;
            r_cnt   <= '0;
            r_len   <= '0;
            r_id    <= '0;
            r_fail  <= 1'b0;
            r_flags <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_id    <= n_id;
            r_fail  <= n_fail;
            r_flags <= n_flags;
        end
    end

    assign o_phase = r_phase;

endmodule

FILE: design/brpc_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one classified byte until the downstream side takes it.
// ----------------------------------------------------------------------------
module brpc_out_reg
    import brpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_result i_result,
    output logic    o_adv,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Move a byte in when the register is empty or is being drained
    assign o_adv = i_in_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load the result on advance
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/binary_rpc_body_parser.sv
// ----------------------------------------------------------------------------
// Binary RPC body parser
// Path: each byte is registered in the input register, then in the result register.
// Throughput: one byte per cycle while m_axis_tready is high; the phase updates once per byte.
// Reset (i_rst_n low, synchronous): parse returns to the version byte, the
// layout register clears to request, and both pipeline registers empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_rpc_body_parser
    import brpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Layout register: bit 0 message_kind
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tlast,   // last_byte
    // Result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] payload_byte, [9:8] status, [73:10] body_id,
    // [74] has_result_flag, [75] has_error_flag, [79:76] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast,   // done_res
    output logic [CLASS_W-1:0] m_axis_tuser    // [2:0] byte_class
);

    logic               r_message_kind;
    logic               in_valid;
    t_item              in_item;
    t_item              s_item;
    logic               adv;
    t_result            core_result;
    t_result            out_result;
    logic [PHASE_W-1:0] phase;

    // Layout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_kind <= KIND_REQUEST;
        end else if (i_cfg_wr_en) begin
            r_message_kind <= i_cfg_wr_data;
        end
    end

    assign s_item.data = s_axis_tdata;
    assign s_item.last = s_axis_tlast;

    brpc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    brpc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_item         (in_item),
        .i_message_kind (r_message_kind),
        .o_result       (core_result),
        .o_phase        (phase)
    );

    brpc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_result   (core_result),
        .o_adv      (adv),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    // Pack the result fields
    assign m_axis_tdata = {4'b0000,
                           out_result.has_error_flag,
                           out_result.has_result_flag,
                           out_result.body_id,
                           out_result.status,
                           out_result.payload_byte};
    assign m_axis_tlast = out_result.done_res;
    assign m_axis_tuser = out_result.byte_class;

    // Status fields stay clear on bytes that do not end the body
    `BRPC_ASSERT(a_not_done_clear,
        !(m_axis_tvalid && !m_axis_tlast) || (m_axis_tdata[TDATA_W-1:DATA_W] == '0),
        "status fields set on a byte that is not the last")

    // A failed body never reports an id
    `BRPC_ASSERT(a_fail_no_id,
        !(m_axis_tvalid && m_axis_tlast && m_axis_tdata[9:8] != ST_OK)
            || (m_axis_tdata[73:10] == '0),
        "id reported with a non-ok status")

    // The last byte of a body leaves the parser waiting for a version byte
    `BRPC_ASSERT_NEXT(a_last_restarts, adv && in_item.last, phase == PH_VER,
        "parse state not cleared after the last byte")

    // An empty result register never stalls the input side
    `BRPC_ASSERT(a_empty_accepts, m_axis_tvalid || s_axis_tready,
        "input stalled while the result register is empty")

endmodule
